// ===== hw/rtl/midi_message_assembler_core_macros.svh =====
// assertion macros used by the midi message assembler checker
`ifndef MIDI_MESSAGE_ASSEMBLER_CORE_MACROS_SVH
`define MIDI_MESSAGE_ASSEMBLER_CORE_MACROS_SVH

// plain property, checked at every rising clock edge outside reset
`define MMA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mma assertion failed");

// implication into the next cycle
`define MMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mma assertion failed");

`endif

// ===== hw/rtl/mma_pkg.sv =====
// types, constants and a decode helper for the midi message assembler
`timescale 1ns / 1ps
`default_nettype none
package mma_pkg;

    localparam int NUM_PORTS = 4;

    typedef logic [1:0]      t_port;
    typedef logic [7:0]      t_byte;
    typedef logic [1:0]      t_len;
    typedef logic [1:0]      t_mode;
    typedef logic [1:0]      t_cnt;
    typedef logic [3:0]      t_mask;
    typedef logic [2:0][7:0] t_msg_buf;

    localparam t_mask MASK_RESET = 4'hf;

    localparam t_mode MODE_IDLE  = 2'd0;
    localparam t_mode MODE_DATA  = 2'd1;
    localparam t_mode MODE_SYSEX = 2'd2;

    localparam t_byte BYTE_ACTIVE_SENSE = 8'hfe;
    localparam t_byte BYTE_SYSEX_START  = 8'hf0;
    localparam t_byte BYTE_SYSEX_END    = 8'hf7;
    localparam t_byte BYTE_MTC_QFRAME   = 8'hf1;
    localparam t_byte BYTE_SONG_POS     = 8'hf2;
    localparam t_byte BYTE_SONG_SEL     = 8'hf3;
    localparam t_byte BYTE_STATUS_FLAG  = 8'h80;

    // data bytes that follow a channel status: program change and channel pressure take one
    function automatic t_cnt chan_data_len(input t_byte status);
        t_cnt len;
        unique case (status[6:4])
            3'd4, 3'd5: len = 2'd1;
            3'd7:       len = 2'd0;
            default:    len = 2'd2;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mma_byte_if.sv =====
// valid/ready channel carrying one received byte and its port
`timescale 1ns / 1ps
`default_nettype none
interface mma_byte_if;
    import mma_pkg::*;

    logic  valid;
    logic  ready;
    t_port port_index;
    t_byte data_byte;

    modport source (output valid, output port_index, output data_byte, input ready);
    modport sink   (input valid, input port_index, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mma_msg_if.sv =====
// valid/ready channel carrying one assembled midi message
`timescale 1ns / 1ps
`default_nettype none
interface mma_msg_if;
    import mma_pkg::*;

    logic  valid;
    logic  ready;
    t_port source_port;
    t_byte msg_status;
    t_byte msg_data1;
    t_byte msg_data2;
    t_len  msg_length;

    modport source (
        output valid, output source_port, output msg_status, output msg_data1,
        output msg_data2, output msg_length, input ready
    );
    modport sink (
        input valid, input source_port, input msg_status, input msg_data1,
        input msg_data2, input msg_length, output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/midi_message_assembler_core.sv =====
// midi message assembler: per-port running status parser, one byte per cycle while o_msg is not stalled
//
// i_byte takes one received byte per transfer, tagged with the port it came
// from. o_msg gives one transfer per completed message: status, up to two
// data bytes and the number of valid bytes. Unused data bytes read as zero.
// Bytes on absent ports (mask bit clear) and active sense bytes are dropped.
// Sysex is skipped up to its end byte and gives no message.
// A byte transfer goes into the input register, then the parse and state
// update write its message into the output register on o_msg. Throughput
// is one byte per cycle while o_msg is not stalled, on any mix of ports,
// since the per-port state is read and written back in the parse cycle.
// When o_msg is stalled a byte in the parse stage is held there and
// i_byte.ready drops until the output register is taken.
// Reset clears both stages, sets every port to idle with no running status
// and the present mask to all ports. The user must write the mask through
// i_cfg_wr_en / i_cfg_wr_data while no bytes are in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module midi_message_assembler_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire mma_pkg::t_mask i_cfg_wr_data,
    mma_byte_if.sink           i_byte,
    mma_msg_if.source          o_msg
);
    import mma_pkg::*;

    // per-port parser state
    t_mode    r_mode [NUM_PORTS];
    t_msg_buf r_buf  [NUM_PORTS];
    t_cnt     r_fill [NUM_PORTS];
    t_cnt     r_due  [NUM_PORTS];
    t_byte    r_rs   [NUM_PORTS];
    t_mask    r_mask;

    // parse stage input register
    logic  r_s1_valid;
    t_port r_s1_port;
    t_byte r_s1_byte;

    // output register
    logic  r_out_valid;
    t_port r_out_port;
    t_byte r_out_status;
    t_byte r_out_data1;
    t_byte r_out_data2;
    t_len  r_out_len;

    logic     w_out_free;
    logic     w_process;
    logic     w_take;
    t_mode    n_mode;
    t_msg_buf n_buf;
    t_cnt     n_fill;
    t_cnt     n_due;
    t_byte    n_rs;
    logic     n_emit;
    t_len     n_len;
    t_byte    n_data1;
    t_byte    n_data2;
    t_cnt     w_rs_due;

    assign w_out_free   = !r_out_valid || o_msg.ready;
    assign i_byte.ready = !r_s1_valid || w_out_free;
    assign w_process    = r_s1_valid && w_out_free;

    assign w_take = (int'(r_s1_port) < NUM_PORTS) && r_mask[r_s1_port]
                    && (r_s1_byte != BYTE_ACTIVE_SENSE);
    assign w_rs_due = chan_data_len(r_rs[r_s1_port]);

    always_comb begin
        n_mode  = r_mode[r_s1_port];
        n_buf   = r_buf[r_s1_port];
        n_fill  = r_fill[r_s1_port];
        n_due   = r_due[r_s1_port];
        n_rs    = r_rs[r_s1_port];
        n_emit  = 1'b0;
        n_len   = 2'd1;
        n_data1 = '0;
        n_data2 = '0;

        unique case (r_mode[r_s1_port])
            MODE_IDLE: begin
                if (r_s1_byte[7]) begin
                    if (r_s1_byte[7:4] == 4'hf) begin
                        if (r_s1_byte == BYTE_SYSEX_START) begin
                            n_mode = MODE_SYSEX;
                        end else if (r_s1_byte == BYTE_MTC_QFRAME
                                     || r_s1_byte == BYTE_SONG_POS
                                     || r_s1_byte == BYTE_SONG_SEL) begin
                            n_mode   = MODE_DATA;
                            n_fill   = 2'd1;
                            n_due    = (r_s1_byte == BYTE_SONG_POS) ? 2'd2 : 2'd1;
                            n_buf[0] = r_s1_byte;
                        end else begin
                            // single byte system message
                            n_buf[0] = r_s1_byte;
                            n_fill   = 2'd1;
                            n_due    = 2'd0;
                            n_emit   = 1'b1;
                        end
                    end else begin
                        n_mode   = MODE_DATA;
                        n_fill   = 2'd1;
                        n_due    = chan_data_len(r_s1_byte);
                        n_buf[0] = r_s1_byte;
                        n_rs     = r_s1_byte;
                    end
                end else if ((r_rs[r_s1_port] & BYTE_STATUS_FLAG) != '0) begin
                    // running status: data byte reuses the last channel status
                    n_buf[0] = r_rs[r_s1_port];
                    n_buf[1] = r_s1_byte;
                    n_fill   = 2'd2;
                    if (w_rs_due > 2'd1) begin
                        n_due  = w_rs_due - 2'd1;
                        n_mode = MODE_DATA;
                    end else begin
                        n_due  = 2'd0;
                        n_mode = MODE_IDLE;
                        n_emit = 1'b1;
                    end
                end
            end
            MODE_DATA: begin
                // any byte, status included, is stored as data here
                if (r_fill[r_s1_port] < 2'd3) begin
                    n_buf[r_fill[r_s1_port]] = r_s1_byte;
                    n_fill = r_fill[r_s1_port] + 2'd1;
                end
                if (r_due[r_s1_port] <= 2'd1) begin
                    n_due  = 2'd0;
                    n_mode = MODE_IDLE;
                    n_emit = 1'b1;
                end else begin
                    n_due = r_due[r_s1_port] - 2'd1;
                end
            end
            MODE_SYSEX: begin
                if (r_s1_byte == BYTE_SYSEX_END) begin
                    n_mode = MODE_IDLE;
                    n_due  = 2'd0;
                    n_fill = 2'd0;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase

        n_len   = (n_fill == 2'd0) ? 2'd1 : n_fill;
        n_data1 = (n_len >= 2'd2) ? n_buf[1] : '0;
        n_data2 = (n_len == 2'd3) ? n_buf[2] : '0;
        if (n_emit) begin
            n_fill = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mask      <= MASK_RESET;
            for (int p = 0; p < NUM_PORTS; p++) begin
                r_mode[p] <= MODE_IDLE;
                r_buf[p]  <= '0;
                r_fill[p] <= '0;
                r_due[p]  <= '0;
                r_rs[p]   <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_mask <= i_cfg_wr_data;
            end
            if (i_byte.ready) begin
                r_s1_valid <= i_byte.valid;
            end
            if (w_process && w_take) begin
                r_mode[r_s1_port] <= n_mode;
                r_buf[r_s1_port]  <= n_buf;
                r_fill[r_s1_port] <= n_fill;
                r_due[r_s1_port]  <= n_due;
                r_rs[r_s1_port]   <= n_rs;
            end
            if (w_out_free) begin
                r_out_valid <= w_process && w_take && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_s1_port <= i_byte.port_index;
            r_s1_byte <= i_byte.data_byte;
        end
        if (w_out_free) begin
            r_out_port   <= r_s1_port;
            r_out_status <= n_buf[0];
            r_out_data1  <= n_data1;
            r_out_data2  <= n_data2;
            r_out_len    <= n_len;
        end
    end

    assign o_msg.valid       = r_out_valid;
    assign o_msg.source_port = r_out_port;
    assign o_msg.msg_status  = r_out_status;
    assign o_msg.msg_data1   = r_out_data1;
    assign o_msg.msg_data2   = r_out_data2;
    assign o_msg.msg_length  = r_out_len;

endmodule
`default_nettype wire

// ===== hw/rtl/mma_checker.sv =====
// port-level checks on the message channel of the midi message assembler
`timescale 1ns / 1ps
`default_nettype none
`include "midi_message_assembler_core_macros.svh"
module mma_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_valid,
    input wire logic           i_ready,
    input wire mma_pkg::t_byte i_status,
    input wire mma_pkg::t_byte i_data1,
    input wire mma_pkg::t_byte i_data2,
    input wire mma_pkg::t_len  i_length
);
    import mma_pkg::*;

    // a stalled message stays on the channel
    `MMA_ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n, i_valid && !i_ready, i_valid)

    // every message opens with a status byte and has a nonzero length
    `MMA_ASSERT(a_status_len, i_clk, i_rst_n, !i_valid || (i_status[7] && i_length != 2'd0))

    // bytes past the length read as zero
    `MMA_ASSERT(a_short_zero, i_clk, i_rst_n, !i_valid || i_length != 2'd1 || (i_data1 == '0 && i_data2 == '0))
    `MMA_ASSERT(a_two_zero, i_clk, i_rst_n, !i_valid || i_length != 2'd2 || i_data2 == '0)

endmodule

bind midi_message_assembler_core mma_checker u_mma_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_msg.valid),
    .i_ready  (o_msg.ready),
    .i_status (o_msg.msg_status),
    .i_data1  (o_msg.msg_data1),
    .i_data2  (o_msg.msg_data2),
    .i_length (o_msg.msg_length)
);
`default_nettype wire
